// ===== sv/qibm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qibm_pkg
// Widths, side-band struct and fixed-point helpers for the quad bilinear map.
// ----------------------------------------------------------------------------
package qibm_pkg;

	localparam int W     = 32;          // coordinate width
	localparam int F     = 16;          // fraction bits
	localparam int EXT   = W + 3;       // headroom for short sums
	localparam int MAGW  = 2 * W + F;   // wide unsigned magnitude
	localparam int DQ    = W + F;       // dividend bits, one per divider stage
	localparam int SQW   = W - 1 + F;   // radicand bits
	localparam int SQB   = (SQW + 1) / 2; // root bits, one per root stage
	localparam int NUM_REGS = 8;
	localparam int CFG_IW   = 4;

	localparam logic FUNC_MAP   = 1'b0;
	localparam logic FUNC_UNMAP = 1'b1;

	typedef logic signed [W-1:0] num_t;

	localparam num_t MAXV    = {1'b0, {(W-1){1'b1}}};
	localparam num_t MINV    = {1'b1, {(W-1){1'b0}}};
	localparam num_t NEG_ONE = -(num_t'(1) <<< F);

	typedef struct packed {
		logic unmap;
		logic fail;
		num_t hx;
		num_t hy;
		num_t a;
		num_t b;
		num_t c;
		num_t v;
		num_t rx;
		num_t ry;
	} side_t;

	function automatic logic signed [EXT-1:0] sx(input num_t a);
		return {{(EXT-W){a[W-1]}}, a};
	endfunction

	function automatic num_t sat_w(input logic signed [EXT-1:0] v);
		if (v > sx(MAXV)) return MAXV;
		if (v < sx(MINV)) return MINV;
		return v[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag(input num_t a);
		return a[W-1] ? (~a + 1'b1) : a;
	endfunction

	// signed value from a magnitude, saturated
	function automatic num_t from_mag(input logic [MAGW-1:0] m, input logic neg);
		logic [MAGW-1:0] lim;
		lim = MAGW'(1) << (W - 1);
		if (m > lim) return neg ? MINV : MAXV;
		if (neg) return -num_t'(m[W-1:0]);
		if (m == lim) return MAXV;
		return m[W-1:0];
	endfunction

	// round half away from zero, drop fraction, saturate
	function automatic num_t round_mul(input logic [2*W-1:0] pm, input logic neg);
		logic [2*W:0] p;
		p = {1'b0, pm} + ((2*W+1)'(1) << (F - 1));
		return from_mag(MAGW'(p >> F), neg);
	endfunction

endpackage

// ===== sv/qibm_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qibm_mul
// Two-stage fixed-point multiply: magnitude product, then round and saturate.
// ----------------------------------------------------------------------------
module qibm_mul import qibm_pkg::*; (
	input  logic clk,
	input  num_t a,
	input  num_t b,
	output num_t p
);

	logic [2*W-1:0] pm_s1;
	logic           neg_s1;
	num_t           p_s2;

	always_ff @(posedge clk) begin
		pm_s1  <= mag(a) * mag(b);
		neg_s1 <= a[W-1] ^ b[W-1];
		p_s2   <= round_mul(pm_s1, neg_s1);
	end

	assign p = p_s2;

endmodule

// ===== sv/qibm_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qibm_sqrt
// Pipelined floor square root of w << F, one root bit per stage.
// ----------------------------------------------------------------------------
module qibm_sqrt import qibm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  num_t  w,
	input  side_t in_side,
	output logic  out_valid,
	output num_t  root,
	output side_t out_side
);

	logic [SQB:0]     rem_s  [SQB];
	logic [SQB-1:0]   rt_s   [SQB];
	logic [2*SQB-1:0] np_s   [SQB];
	side_t            side_s [SQB];
	logic             v_s    [SQB];

	logic  v_q;
	num_t  root_q;
	side_t side_q;

	for (genvar k = 0; k < SQB; k++) begin : g_stage
		logic [SQB:0]     p_rem;
		logic [SQB-1:0]   p_rt;
		logic [2*SQB-1:0] p_np;
		side_t            p_side;
		logic             p_v;
		logic [SQB+2:0]   t;
		logic [SQB+2:0]   trial;

		if (k == 0) begin : g_first
			assign p_rem  = '0;
			assign p_rt   = '0;
			assign p_np   = (2*SQB)'({w[W-2:0], {F{1'b0}}});
			assign p_side = in_side;
			assign p_v    = in_valid;
		end else begin : g_next
			assign p_rem  = rem_s[k-1];
			assign p_rt   = rt_s[k-1];
			assign p_np   = np_s[k-1];
			assign p_side = side_s[k-1];
			assign p_v    = v_s[k-1];
		end

		assign t     = {p_rem, p_np[2*SQB-1 -: 2]};
		assign trial = (SQB+3)'({p_rt, 2'b01});

		always_ff @(posedge clk) begin
			if (t >= trial) begin
				rem_s[k] <= (SQB+1)'(t - trial);
				rt_s[k]  <= {p_rt[SQB-2:0], 1'b1};
			end else begin
				rem_s[k] <= (SQB+1)'(t);
				rt_s[k]  <= {p_rt[SQB-2:0], 1'b0};
			end
			np_s[k]   <= p_np << 2;
			side_s[k] <= p_side;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= p_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		root_q <= from_mag(MAGW'(rt_s[SQB-1]), 1'b0);
		side_q <= side_s[SQB-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_s[SQB-1];
		end
	end

	assign out_valid = v_q;
	assign root      = root_q;
	assign out_side  = side_q;

endmodule

// ===== sv/qibm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qibm_div
// Pipelined restoring divide (num << F) / den, truncated toward zero,
// one quotient bit per stage, saturated at the end.
// ----------------------------------------------------------------------------
module qibm_div import qibm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  num_t  num,
	input  num_t  den,
	input  side_t in_side,
	output logic  out_valid,
	output num_t  quo,
	output side_t out_side
);

	logic [W-1:0]  rem_s  [DQ];
	logic [DQ-1:0] nd_s   [DQ];
	logic [DQ-1:0] q_s    [DQ];
	logic [W-1:0]  dm_s   [DQ];
	logic          neg_s  [DQ];
	side_t         side_s [DQ];
	logic          v_s    [DQ];

	logic  v_q;
	num_t  quo_q;
	side_t side_q;

	for (genvar k = 0; k < DQ; k++) begin : g_stage
		logic [W-1:0]  p_rem;
		logic [DQ-1:0] p_nd;
		logic [DQ-1:0] p_q;
		logic [W-1:0]  p_dm;
		logic          p_neg;
		side_t         p_side;
		logic          p_v;
		logic [W:0]    t;

		if (k == 0) begin : g_first
			assign p_rem  = '0;
			assign p_nd   = {mag(num), {F{1'b0}}};
			assign p_q    = '0;
			assign p_dm   = mag(den);
			assign p_neg  = num[W-1] ^ den[W-1];
			assign p_side = in_side;
			assign p_v    = in_valid;
		end else begin : g_next
			assign p_rem  = rem_s[k-1];
			assign p_nd   = nd_s[k-1];
			assign p_q    = q_s[k-1];
			assign p_dm   = dm_s[k-1];
			assign p_neg  = neg_s[k-1];
			assign p_side = side_s[k-1];
			assign p_v    = v_s[k-1];
		end

		assign t = {p_rem, p_nd[DQ-1]};

		always_ff @(posedge clk) begin
			if (t >= {1'b0, p_dm}) begin
				rem_s[k] <= W'(t - {1'b0, p_dm});
				q_s[k]   <= {p_q[DQ-2:0], 1'b1};
			end else begin
				rem_s[k] <= W'(t);
				q_s[k]   <= {p_q[DQ-2:0], 1'b0};
			end
			nd_s[k]   <= p_nd << 1;
			dm_s[k]   <= p_dm;
			neg_s[k]  <= p_neg;
			side_s[k] <= p_side;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= p_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		quo_q  <= from_mag(MAGW'(q_s[DQ-1]), neg_s[DQ-1]);
		side_q <= side_s[DQ-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_s[DQ-1];
		end
	end

	assign out_valid = v_q;
	assign quo       = quo_q;
	assign out_side  = side_q;

endmodule

// ===== sv/quad_inverse_bilinear_map_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_inverse_bilinear_map_core
// Inverse (point to u,v) and forward (u,v to point) bilinear map of one quad,
// signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  transaction
//  --------  ---------------------------------------  ------------------------
//  command   start, busy, func, in_x, in_y            start & !busy at clk
//  result    done, out_x, out_y, no_solution          done high for one cycle
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
//  - One command per cycle is taken; busy is never raised.
//  - The latency from start to done is set by the root pipeline (SQB stages)
//    and two dividers (DQ each), whose sizes follow W and F (Q16.16 here).
//  - The result side cannot stall, so nothing in the pipe ever waits.
//  - Reset clears corners to zero and all valid bits; data registers are not reset.
//  - Corners feed the pipe directly; write them only with no command in flight.
//
module quad_inverse_bilinear_map_core import qibm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  num_t              in_x,
	input  num_t              in_y,
	output logic              done,
	output num_t              out_x,
	output num_t              out_y,
	output logic              no_solution,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [W-1:0]      cfg_data
);

	// ---------------- corner registers ----------------
	num_t cx_q [4];
	num_t cy_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				cx_q[i] <= '0;
				cy_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready && cfg_index < CFG_IW'(NUM_REGS)) begin
			if (cfg_index[0]) begin
				cy_q[cfg_index[2:1]] <= cfg_data;
			end else begin
				cx_q[cfg_index[2:1]] <= cfg_data;
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// corner-derived terms; the user must keep them static while commands are in flight, the block does not enforce it
	num_t ex, ey, fx, fy, gx, gy, d32x, d32y;
	assign ex   = sat_w(sx(cx_q[1]) - sx(cx_q[0]));
	assign ey   = sat_w(sx(cy_q[1]) - sx(cy_q[0]));
	assign fx   = sat_w(sx(cx_q[3]) - sx(cx_q[0]));
	assign fy   = sat_w(sx(cy_q[3]) - sx(cy_q[0]));
	assign gx   = sat_w(sx(cx_q[0]) - sx(cx_q[1]) + sx(cx_q[2]) - sx(cx_q[3]));
	assign gy   = sat_w(sx(cy_q[0]) - sx(cy_q[1]) + sx(cy_q[2]) - sx(cy_q[3]));
	assign d32x = sat_w(sx(cx_q[2]) - sx(cx_q[3]));
	assign d32y = sat_w(sx(cy_q[2]) - sx(cy_q[3]));

	// ---------------- s1: capture command ----------------
	logic v_s1, un_s1;
	num_t x_s1, y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		un_s1 <= (func == FUNC_UNMAP);
		x_s1  <= in_x;
		y_s1  <= in_y;
	end

	// ---------------- s2: offset from corner 0 ----------------
	logic v_s2, un_s2;
	num_t hx_s2, hy_s2, u_s2, t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		un_s2 <= un_s1;
		hx_s2 <= sat_w(sx(x_s1) - sx(cx_q[0]));
		hy_s2 <= sat_w(sx(y_s1) - sx(cy_q[0]));
		u_s2  <= x_s1;
		t_s2  <= y_s1;
	end

	// ---------------- s3..s4: first product rank ----------------
	num_t m_ef0, m_ef1, m_hg0, m_hg1, m_he0, m_he1, m_gf0, m_gf1;
	num_t m_ax, m_ay, m_bx, m_by;

	qibm_mul u_m_ef0 (.clk, .a(ex),    .b(fy),   .p(m_ef0));
	qibm_mul u_m_ef1 (.clk, .a(ey),    .b(fx),   .p(m_ef1));
	qibm_mul u_m_hg0 (.clk, .a(hx_s2), .b(gy),   .p(m_hg0));
	qibm_mul u_m_hg1 (.clk, .a(hy_s2), .b(gx),   .p(m_hg1));
	qibm_mul u_m_he0 (.clk, .a(hx_s2), .b(ey),   .p(m_he0));
	qibm_mul u_m_he1 (.clk, .a(hy_s2), .b(ex),   .p(m_he1));
	qibm_mul u_m_gf0 (.clk, .a(gx),    .b(fy),   .p(m_gf0));
	qibm_mul u_m_gf1 (.clk, .a(gy),    .b(fx),   .p(m_gf1));
	qibm_mul u_m_ax  (.clk, .a(ex),    .b(u_s2), .p(m_ax));
	qibm_mul u_m_ay  (.clk, .a(ey),    .b(u_s2), .p(m_ay));
	qibm_mul u_m_bx  (.clk, .a(d32x),  .b(u_s2), .p(m_bx));
	qibm_mul u_m_by  (.clk, .a(d32y),  .b(u_s2), .p(m_by));

	logic v_s3, un_s3, v_s4, un_s4;
	num_t hx_s3, hy_s3, t_s3, hx_s4, hy_s4, t_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		un_s3 <= un_s2;
		hx_s3 <= hx_s2;
		hy_s3 <= hy_s2;
		t_s3  <= t_s2;
		un_s4 <= un_s3;
		hx_s4 <= hx_s3;
		hy_s4 <= hy_s3;
		t_s4  <= t_s3;
	end

	// ---------------- s5: cross products, first lerp ----------------
	logic v_s5, un_s5;
	num_t hx_s5, hy_s5, t_s5, a_s5, cef_s5, chg_s5, c_s5;
	num_t ax_s5, ay_s5, bx_s5, by_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		un_s5  <= un_s4;
		hx_s5  <= hx_s4;
		hy_s5  <= hy_s4;
		t_s5   <= t_s4;
		a_s5   <= sat_w(sx(m_gf0) - sx(m_gf1));
		cef_s5 <= sat_w(sx(m_ef0) - sx(m_ef1));
		chg_s5 <= sat_w(sx(m_hg0) - sx(m_hg1));
		c_s5   <= sat_w(sx(m_he0) - sx(m_he1));
		ax_s5  <= sat_w(sx(cx_q[0]) + sx(m_ax));
		ay_s5  <= sat_w(sx(cy_q[0]) + sx(m_ay));
		bx_s5  <= sat_w(sx(cx_q[3]) + sx(m_bx));
		by_s5  <= sat_w(sx(cy_q[3]) + sx(m_by));
	end

	// ---------------- s6: linear term b, second lerp span ----------------
	logic  v_s6;
	side_t side_s6;
	num_t  t_s6, dx_s6, dy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		side_s6.unmap <= un_s5;
		side_s6.fail  <= 1'b0;
		side_s6.hx    <= hx_s5;
		side_s6.hy    <= hy_s5;
		side_s6.a     <= a_s5;
		side_s6.b     <= sat_w(sx(cef_s5) + sx(chg_s5));
		side_s6.c     <= c_s5;
		side_s6.v     <= '0;
		side_s6.rx    <= ax_s5;
		side_s6.ry    <= ay_s5;
		t_s6          <= t_s5;
		dx_s6         <= sat_w(sx(bx_s5) - sx(ax_s5));
		dy_s6         <= sat_w(sx(by_s5) - sx(ay_s5));
	end

	// ---------------- s7..s8: second product rank ----------------
	num_t m_bb, m_ac, m_rx, m_ry;

	qibm_mul u_m_bb (.clk, .a(side_s6.b), .b(side_s6.b), .p(m_bb));
	qibm_mul u_m_ac (.clk, .a(side_s6.a), .b(side_s6.c), .p(m_ac));
	qibm_mul u_m_rx (.clk, .a(dx_s6),     .b(t_s6),      .p(m_rx));
	qibm_mul u_m_ry (.clk, .a(dy_s6),     .b(t_s6),      .p(m_ry));

	logic  v_s7, v_s8;
	side_t side_s7, side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		side_s7 <= side_s6;
		side_s8 <= side_s7;
	end

	// ---------------- s9: discriminant, forward result ----------------
	num_t  disc;
	logic  fail1;
	logic  v_s9;
	side_t side_s9;
	num_t  w_s9;

	assign disc  = sat_w(sx(m_bb) - (sx(m_ac) <<< 2));
	assign fail1 = (side_s8.a != '0) ? disc[W-1] : (side_s8.b == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		side_s9      <= side_s8;
		side_s9.fail <= fail1;
		side_s9.rx   <= sat_w(sx(side_s8.rx) + sx(m_rx));
		side_s9.ry   <= sat_w(sx(side_s8.ry) + sx(m_ry));
		w_s9         <= disc[W-1] ? '0 : disc;
	end

	// ---------------- root pipeline ----------------
	logic  sq_v;
	num_t  sq_root;
	side_t sq_side;

	qibm_sqrt u_sqrt (
		.clk,
		.arst_n,
		.in_valid (v_s9),
		.w        (w_s9),
		.in_side  (side_s9),
		.out_valid(sq_v),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// ---------------- s10: quadratic or linear operands for v ----------------
	logic  v_s10;
	num_t  num_s10, den_s10;
	side_t side_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		side_s10 <= sq_side;
		if (sq_side.a != '0) begin
			num_s10 <= sat_w(sx(sq_root) - sx(sq_side.b));
			den_s10 <= sat_w(sx(sq_side.a) <<< 1);
		end else begin
			num_s10 <= sat_w(-sx(sq_side.c));
			den_s10 <= sq_side.b;
		end
	end

	logic  d1_v;
	num_t  d1_q;
	side_t d1_side;

	qibm_div u_div_v (
		.clk,
		.arst_n,
		.in_valid (v_s10),
		.num      (num_s10),
		.den      (den_s10),
		.in_side  (side_s10),
		.out_valid(d1_v),
		.quo      (d1_q),
		.out_side (d1_side)
	);

	// ---------------- s11..s12: u numerator and denominator products ----------------
	num_t m_gxv, m_fxv, m_gyv, m_fyv;

	qibm_mul u_m_gxv (.clk, .a(gx), .b(d1_q), .p(m_gxv));
	qibm_mul u_m_fxv (.clk, .a(fx), .b(d1_q), .p(m_fxv));
	qibm_mul u_m_gyv (.clk, .a(gy), .b(d1_q), .p(m_gyv));
	qibm_mul u_m_fyv (.clk, .a(fy), .b(d1_q), .p(m_fyv));

	logic  v_s11, v_s12;
	side_t side_s11, side_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			v_s11 <= d1_v;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		side_s11   <= d1_side;
		side_s11.v <= d1_q;
		side_s12   <= side_s11;
	end

	// ---------------- s13: pick x or y denominator ----------------
	num_t dd1, nn1, dd2, nn2;
	logic v_s13;
	num_t num_s13, den_s13;
	side_t side_s13;

	assign dd1 = sat_w(sx(ex) + sx(m_gxv));
	assign nn1 = sat_w(sx(side_s12.hx) - sx(m_fxv));
	assign dd2 = sat_w(sx(ey) + sx(m_gyv));
	assign nn2 = sat_w(sx(side_s12.hy) - sx(m_fyv));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		side_s13      <= side_s12;
		side_s13.fail <= side_s12.fail || (dd1 == '0 && dd2 == '0);
		if (dd1 != '0) begin
			num_s13 <= nn1;
			den_s13 <= dd1;
		end else begin
			num_s13 <= nn2;
			den_s13 <= dd2;
		end
	end

	logic  d2_v;
	num_t  d2_q;
	side_t d2_side;

	qibm_div u_div_u (
		.clk,
		.arst_n,
		.in_valid (v_s13),
		.num      (num_s13),
		.den      (den_s13),
		.in_side  (side_s13),
		.out_valid(d2_v),
		.quo      (d2_q),
		.out_side (d2_side)
	);

	// ---------------- result register ----------------
	logic done_q, nosol_q;
	num_t ox_q, oy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (d2_side.unmap) begin
			ox_q    <= d2_side.rx;
			oy_q    <= d2_side.ry;
			nosol_q <= 1'b0;
		end else if (d2_side.fail) begin
			ox_q    <= NEG_ONE;
			oy_q    <= NEG_ONE;
			nosol_q <= 1'b1;
		end else begin
			ox_q    <= d2_q;
			oy_q    <= d2_side.v;
			nosol_q <= 1'b0;
		end
	end

	assign done        = done_q;
	assign out_x       = ox_q;
	assign out_y       = oy_q;
	assign no_solution = nosol_q;

	// ---------------- checks ----------------
	a_nosol_value: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && nosol_q |-> ox_q == NEG_ONE && oy_q == NEG_ONE)
		else $error("no_solution without -1 outputs");

	a_tail_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_s13 |-> ##(DQ + 2) done_q)
		else $error("transaction lost in u divider");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(v_s13, DQ + 2))
		else $error("result strobe without transaction");

	a_root_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> ##(SQB + 1) sq_v)
		else $error("root pipeline latency mismatch");

endmodule
